// File: hdl/slps_pkg.sv
// Package for the status LED pattern sequencer: register indexes, mode codes,
// result beat type and the per-mode pattern tables.
// No dependencies.
package slps_pkg;

  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned ModeWidth   = 3;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 16;
  // Widest mode pattern; the user keeps the phase register no narrower, unenforced.
  localparam int unsigned PatWidth    = 12;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PERIOD  = 2'd0,
    REG_RED     = 2'd1,
    REG_GREEN   = 2'd2,
    REG_BICOLOR = 2'd3
  } cfg_reg_e;

  typedef enum logic [ModeWidth-1:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_BLINK  = 3'd2,
    MODE_SINGLE = 3'd3,
    MODE_DOUBLE = 3'd4,
    MODE_TRIPLE = 3'd5,
    MODE_QUAD   = 3'd6
  } mode_e;

  typedef struct packed {
    logic red_led;
    logic green_led;
    logic stepped;
  } result_t;

  // Shift mask of a mode; code 7 behaves as off.
  function automatic logic [PatWidth-1:0] mode_mask(logic [ModeWidth-1:0] mode);
    logic [PatWidth-1:0] m;
    case (mode)
      MODE_ON:     m = 12'h001;
      MODE_BLINK:  m = 12'h003;
      MODE_SINGLE: m = 12'h03F;
      MODE_DOUBLE: m = 12'h0FF;
      MODE_TRIPLE: m = 12'h3FF;
      MODE_QUAD:   m = 12'hFFF;
      default:     m = 12'h001;
    endcase
    return m;
  endfunction

  // On-pattern of a mode; green blink runs in the other phase.
  function automatic logic [PatWidth-1:0] mode_on(logic [ModeWidth-1:0] mode,
                                                  logic is_green);
    logic [PatWidth-1:0] p;
    case (mode)
      MODE_ON:     p = 12'h001;
      MODE_BLINK:  p = is_green ? 12'h002 : 12'h001;
      MODE_SINGLE: p = 12'h001;
      MODE_DOUBLE: p = 12'h005;
      MODE_TRIPLE: p = 12'h015;
      MODE_QUAD:   p = 12'h055;
      default:     p = 12'h000;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/status_led_pattern_sequencer_core.sv
// Status LED pattern sequencer: tick counter, phase registers, LED levels and
// a two-entry output buffer. Depends on slps_pkg.
//
// Usage: every input beat carries one tick_i bit (1 = one timer tick passed).
// Every input beat yields exactly one output beat with the red and green LED
// levels held after that tick and a stepped flag set when the tick advanced
// the pattern. A period of zero freezes the pattern.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 period, 1 red mode, 2 green mode, 3 bicolor wiring) at the clock edge,
// no wait, no read-back. Write only while the block is idle.
// An accepted beat's result goes into the output register or the skid entry.
// Throughput: one beat per cycle while the skid entry is empty; the whole
// update is a decrement, a compare and a one-bit shift of each phase register
// between the input edge and the result register.
// Stall: an output register plus one skid entry; the input side keeps taking
// beats while one result waits, and in_ready_o drops only when both hold.
// Reset: rst_ni clears registers to zero, phases to one, LEDs off, buffer empty.
module status_led_pattern_sequencer_core
  import slps_pkg::*;
#(
  parameter int unsigned PHASE_WIDTH = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  // tick beats in
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   tick_i,
  // LED beats out
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   red_led_o,
  output logic                   green_led_o,
  output logic                   stepped_o
);

  localparam logic [PHASE_WIDTH-1:0] PhaseOne = PHASE_WIDTH'(1);

  // Configuration registers
  logic [PeriodWidth-1:0] period_q;
  logic [ModeWidth-1:0]   red_mode_q, green_mode_q;
  logic                   bicolor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= '0;
      red_mode_q   <= MODE_OFF;
      green_mode_q <= MODE_OFF;
      bicolor_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PERIOD:  period_q     <= cfg_wdata_i[PeriodWidth-1:0];
        REG_RED:     red_mode_q   <= cfg_wdata_i[ModeWidth-1:0];
        REG_GREEN:   green_mode_q <= cfg_wdata_i[ModeWidth-1:0];
        REG_BICOLOR: bicolor_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic [PeriodWidth-1:0] cnt_q, cnt_d;
  logic [PHASE_WIDTH-1:0] red_pos_q, red_pos_d, green_pos_q, green_pos_d;
  logic                   red_lvl_q, red_lvl_d, green_lvl_q, green_lvl_d;

  logic                   accept;
  logic                   run, step;
  logic [PHASE_WIDTH-1:0] red_wrap, red_on, green_wrap, green_on;
  logic [PHASE_WIDTH-1:0] red_shift, green_shift;
  logic                   red_bit, green_bit;
  result_t                result;

  assign accept = in_valid_i & in_ready_o;

  always_comb begin
    red_wrap   = PHASE_WIDTH'(mode_mask(red_mode_q));
    red_on     = PHASE_WIDTH'(mode_on(red_mode_q, 1'b0));
    green_wrap = PHASE_WIDTH'(mode_mask(green_mode_q));
    green_on   = PHASE_WIDTH'(mode_on(green_mode_q, 1'b1));

    run  = tick_i & (period_q != '0);
    // countdown at zero or one: step now and reload
    step = run & (cnt_q[PeriodWidth-1:1] == '0);

    red_bit   = |(red_pos_q & red_on);
    green_bit = |(green_pos_q & green_on);

    red_shift   = (red_pos_q << 1) & red_wrap;
    green_shift = (green_pos_q << 1) & green_wrap;

    cnt_d       = cnt_q;
    red_pos_d   = red_pos_q;
    green_pos_d = green_pos_q;
    red_lvl_d   = red_lvl_q;
    green_lvl_d = green_lvl_q;

    if (step) begin
      cnt_d       = period_q;
      red_pos_d   = (red_shift == '0) ? PhaseOne : red_shift;
      green_pos_d = (green_shift == '0) ? PhaseOne : green_shift;
      // bicolor: a lit red bit wins over green
      if (bicolor_q && red_bit) begin
        red_lvl_d   = 1'b1;
        green_lvl_d = 1'b0;
      end else begin
        red_lvl_d   = red_bit;
        green_lvl_d = green_bit;
      end
    end else if (run) begin
      cnt_d = cnt_q - PeriodWidth'(1);
    end

    result.red_led   = red_lvl_d;
    result.green_led = green_lvl_d;
    result.stepped   = step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      red_pos_q   <= PhaseOne;
      green_pos_q <= PhaseOne;
      red_lvl_q   <= 1'b0;
      green_lvl_q <= 1'b0;
    end else if (accept) begin
      cnt_q       <= cnt_d;
      red_pos_q   <= red_pos_d;
      green_pos_q <= green_pos_d;
      red_lvl_q   <= red_lvl_d;
      green_lvl_q <= green_lvl_d;
    end
  end

  // Output register with one skid entry behind it
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    pop;

  assign pop        = out_valid_q & out_ready_i;
  assign in_ready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_led_o   = out_q.red_led;
  assign green_led_o = out_q.green_led;
  assign stepped_o   = out_q.stepped;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for status_led_pattern_sequencer_core: tick beats in,
// LED beats out, with an in-bench model of the indicator patterns.
// Depends on slps_pkg and the core RTL.
module testbench;
  import slps_pkg::*;

  localparam int unsigned PhaseW = 12;
  // Mode code with no table entry; the core must treat it as off.
  localparam logic [ModeWidth-1:0] MODE_UNUSED = 3'd7;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxPrinted = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index_i = REG_PERIOD;
  logic [CfgWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic tick_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic red_led_o;
  logic green_led_o;
  logic stepped_o;

  status_led_pattern_sequencer_core #(
    .PHASE_WIDTH(PhaseW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .tick_i     (tick_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_led_o  (red_led_o),
    .green_led_o(green_led_o),
    .stepped_o  (stepped_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  logic    tick_queue[$];      // tick beats waiting for the driver
  result_t led_expect_q[$];    // LED beats predicted, oldest first
  bit      in_taken;           // input beat accepted at the last rising edge
  bit      calm;               // no gaps on either side while set
  int      holdoff_req;        // receiver picks this up and holds off that long
  int      err_count;
  int      beats_checked;
  int      steps_seen;
  int      cfg_writes;
  int      in_stall_cycles;
  int      idle_cycles;
  result_t want;

  // Register copies seen by the prediction
  logic [PeriodWidth-1:0] period_q;
  logic [ModeWidth-1:0]   red_mode_q;
  logic [ModeWidth-1:0]   green_mode_q;
  logic                   bicolor_q;

  // Sequencer state as the prediction tracks it; reset values match the core
  logic [PeriodWidth-1:0] countdown_q = '0;
  logic [PhaseW-1:0]      red_pos_q = PhaseW'(1);
  logic [PhaseW-1:0]      green_pos_q = PhaseW'(1);
  logic                   red_lvl_q = 1'b0;
  logic                   green_lvl_q = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  // Shift mask and lit positions per mode. Green blink lights on the odd
  // position so the two LEDs alternate.
  function automatic void pattern_of(input logic [ModeWidth-1:0] mode, input logic is_green,
                                     output logic [PhaseW-1:0] mask,
                                     output logic [PhaseW-1:0] lit);
    mask = PhaseW'(1);
    lit  = '0;
    case (mode)
      MODE_ON: begin
        lit = PhaseW'(1);
      end
      MODE_BLINK: begin
        mask = PhaseW'('h3);
        lit  = is_green ? PhaseW'('h2) : PhaseW'('h1);
      end
      MODE_SINGLE: begin
        mask = PhaseW'('h3F);
        lit  = PhaseW'('h1);
      end
      MODE_DOUBLE: begin
        mask = PhaseW'('hFF);
        lit  = PhaseW'('h5);
      end
      MODE_TRIPLE: begin
        mask = PhaseW'('h3FF);
        lit  = PhaseW'('h15);
      end
      MODE_QUAD: begin
        mask = PhaseW'('hFFF);
        lit  = PhaseW'('h55);
      end
      default: begin
        mask = PhaseW'(1);   // off, and the unused code
      end
    endcase
  endfunction

  // Position walks left inside the mask and restarts at bit 0 once it falls out.
  function automatic logic [PhaseW-1:0] next_position(input logic [PhaseW-1:0] pos,
                                                      input logic [PhaseW-1:0] mask);
    logic [PhaseW-1:0] nxt;
    nxt = (pos << 1) & mask;
    return (nxt == '0) ? PhaseW'(1) : nxt;
  endfunction

  // One accepted tick beat: update the tracked state, return the LED beat.
  function automatic result_t advance_indicator(input logic tick);
    result_t           r;
    logic [PhaseW-1:0] rmask, rlit, gmask, glit;
    logic              rbit, gbit;
    r.stepped = 1'b0;
    if (tick && period_q != '0) begin
      if (countdown_q <= PeriodWidth'(1)) begin
        countdown_q = period_q;
        pattern_of(red_mode_q, 1'b0, rmask, rlit);
        pattern_of(green_mode_q, 1'b1, gmask, glit);
        rbit = |(red_pos_q & rlit);
        gbit = |(green_pos_q & glit);
        // A bicolor LED shows red whenever red is lit
        if (bicolor_q && rbit) begin
          red_lvl_q   = 1'b1;
          green_lvl_q = 1'b0;
        end else begin
          red_lvl_q   = rbit;
          green_lvl_q = gbit;
        end
        red_pos_q   = next_position(red_pos_q, rmask);
        green_pos_q = next_position(green_pos_q, gmask);
        r.stepped   = 1'b1;
      end else begin
        countdown_q = countdown_q - PeriodWidth'(1);
      end
    end
    r.red_led   = red_lvl_q;
    r.green_led = green_lvl_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic exp_bit);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("MISMATCH beat %0d: %s is %b, expected %b", beats_checked, what, got, exp_bit);
    end
  endtask

  // Register write; the bench copy is updated here since the core is idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_PERIOD:  period_q     = val[PeriodWidth-1:0];
      REG_RED:     red_mode_q   = val[ModeWidth-1:0];
      REG_GREEN:   green_mode_q = val[ModeWidth-1:0];
      REG_BICOLOR: bicolor_q    = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // All four registers; junk above the mode and wiring bits must be dropped.
  task automatic setup_leds(input logic [PeriodWidth-1:0] period,
                            input logic [ModeWidth-1:0] red, input logic [ModeWidth-1:0] green,
                            input logic bicolor);
    logic [CfgWidth-1:0] junk;
    junk = CfgWidth'($urandom);
    write_reg(REG_PERIOD, period);
    write_reg(REG_RED, {junk[CfgWidth-1:ModeWidth], red});
    junk = CfgWidth'($urandom);
    write_reg(REG_GREEN, {junk[CfgWidth-1:ModeWidth], green});
    junk = CfgWidth'($urandom);
    write_reg(REG_BICOLOR, {junk[CfgWidth-1:1], bicolor});
  endtask

  // Mostly real ticks, the odd beat where no time passed.
  task automatic push_ticks(input int n);
    repeat (n) tick_queue.push_back($urandom_range(0, 9) != 0);
  endtask

  // Sender stops until every predicted LED beat has come back.
  task automatic drain();
    while (tick_queue.size() != 0 || in_valid_i || led_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: tick beats, changed on the falling edge
  // ---------------------------------------------------------------------------
  int send_gap;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        tick_i     <= tick_queue.pop_front();
        send_gap   = calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int hold_left;
  int rx_stall;

  always @(negedge clk_i) begin
    if (holdoff_req > 0) begin
      hold_left   = holdoff_req;
      holdoff_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      rx_stall    = calm ? 0 : pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the rising edge, plus watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid_i && in_ready_o;
      if (in_valid_i && !in_ready_o) in_stall_cycles++;
      // Check the outgoing beat first: a beat pushed this edge is never the one leaving.
      if (out_valid_o && out_ready_i) begin
        if (led_expect_q.size() == 0) begin
          report_mismatch("unexpected beat, out_valid", out_valid_o, 1'b0);
        end else begin
          want = led_expect_q.pop_front();
          if (red_led_o !== want.red_led) report_mismatch("red_led", red_led_o, want.red_led);
          if (green_led_o !== want.green_led) begin
            report_mismatch("green_led", green_led_o, want.green_led);
          end
          if (stepped_o !== want.stepped) report_mismatch("stepped", stepped_o, want.stepped);
          if (want.stepped) steps_seen++;
          beats_checked++;
        end
      end
      if (in_taken) led_expect_q.push_back(advance_indicator(tick_i));
      if (in_taken || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("WATCHDOG: no beat moved for %0d cycles", idle_cycles);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [PeriodWidth-1:0] period;
    period_q     = '0;
    red_mode_q   = MODE_OFF;
    green_mode_q = MODE_OFF;
    bicolor_q    = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Out of reset the period is zero: stopped, LEDs dark, nothing steps.
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    drain();

    // Period 1, first tick after reset steps at once; a zero tick changes nothing.
    setup_leds(16'd1, MODE_ON, MODE_BLINK, 1'b0);
    tick_queue.push_back(1'b0);
    repeat (4) tick_queue.push_back(1'b1);
    drain();

    // Bicolor wiring: red wins whenever it is lit.
    setup_leds(16'd1, MODE_BLINK, MODE_ON, 1'b1);
    repeat (4) tick_queue.push_back(1'b1);
    drain();

    // Unused mode code behaves as off; green moves from on to quad flash.
    setup_leds(16'd1, MODE_UNUSED, MODE_QUAD, 1'b0);
    repeat (3) tick_queue.push_back(1'b1);
    drain();

    // Period changes keep the running countdown.
    write_reg(REG_PERIOD, 16'd3);
    repeat (4) tick_queue.push_back(1'b1);
    drain();
    write_reg(REG_PERIOD, 16'd2);
    repeat (3) tick_queue.push_back(1'b1);
    drain();

    // Random phases: short periods so the patterns turn over many times.
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 5);
      if (ph == 3) begin
        period = '0;
      end else if ($urandom_range(0, 9) < 8) begin
        period = PeriodWidth'($urandom_range(1, 4));
      end else begin
        period = PeriodWidth'($urandom_range(5, 24));
      end
      setup_leds(period, ModeWidth'($urandom_range(0, 7)), ModeWidth'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)));
      if (ph == 2) begin
        // Receiver sits out while ticks keep coming, so the core backs up.
        push_ticks(100);
        holdoff_req = HoldoffCycles;
      end else if (ph == 4) begin
        push_ticks(50);
        drain();
        push_ticks(50);
      end else begin
        push_ticks(100);
      end
      drain();
    end
    calm = 1'b0;

    // Longest period: one reload to 0xFFFF, then a short period that must wait
    // for that countdown to run down.
    setup_leds(16'hFFFF, MODE_QUAD, MODE_TRIPLE, 1'b0);
    repeat (20) tick_queue.push_back(1'b1);
    drain();
    write_reg(REG_PERIOD, 16'd1);
    push_ticks(10);
    drain();

    repeat (10) @(negedge clk_i);
    $display("Checked %0d LED beats, %0d pattern steps, %0d register writes",
             beats_checked, steps_seen, cfg_writes);
    $display("All modes incl. the unused code, both wirings, periods 0 to 0xFFFF, %0d stall cycles",
             in_stall_cycles);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
